>>> sv/kol_pkg.sv
// ----------------------------------------------------------------------------
// kol_pkg: shared types and constants for the keyed compacting order list
// Field widths, operation codes and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package kol_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned PRICE_W   = 24;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned S_TDATA_W = 64;  // key, price, index, padded to bytes
  localparam int unsigned M_TDATA_W = 64;  // ok, key_out, price_out, count

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_DEL_FRONT = 3'd1,
    OP_DEL_KEY   = 3'd2,
    OP_READ      = 3'd3,
    OP_WRITE     = 3'd4
  } op_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
  } entry_t;

  // Broadcast to every cell; only the cell holding the token acts on it.
  typedef struct packed {
    logic   wr;         // overwrite this slot with data
    logic   cap;        // copy this slot into the travelling capture
    logic   del_key;    // delete-by-key walk: compare keys
    logic   force_del;  // unconditional removal of this slot
    logic   in_range;   // slot lies below the entry count
    entry_t data;
  } cmd_t;

endpackage

>>> sv/kol_cell.sv
// ----------------------------------------------------------------------------
// kol_cell: one slot of the order list
// Holds one entry; acts on the broadcast command while the walk token sits
// here and hands token, shift flag and capture on to the next slot.
// ----------------------------------------------------------------------------
module kol_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tok_i,
  input  logic           sh_i,
  input  kol_pkg::entry_t carry_i,
  input  kol_pkg::entry_t next_i,
  input  kol_pkg::cmd_t  cmd_i,
  output logic           tok_o,
  output logic           sh_o,
  output kol_pkg::entry_t carry_o,
  output kol_pkg::entry_t ent_o
);
  import kol_pkg::*;

  entry_t ent_q, ent_d;
  entry_t carry_q, carry_d;
  logic   tok_q, sh_q, sh_d;
  logic   hit, shift;

  // first match wins: once shifting has started the compare no longer matters
  assign hit   = cmd_i.del_key & cmd_i.in_range & (ent_q.key == cmd_i.data.key);
  assign shift = sh_i | hit | cmd_i.force_del;

  always_comb begin
    ent_d = ent_q;
    if (tok_i) begin
      if (shift) begin
        ent_d = next_i;
      end else if (cmd_i.wr) begin
        ent_d = cmd_i.data;
      end
    end
  end

  assign carry_d = (tok_i & cmd_i.cap) ? ent_q : carry_i;
  assign sh_d    = tok_i & shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      sh_q  <= 1'b0;
    end else begin
      tok_q <= tok_i;
      sh_q  <= sh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    carry_q <= carry_d;
  end

  assign tok_o   = tok_q;
  assign sh_o    = sh_q;
  assign carry_o = carry_q;
  assign ent_o   = ent_q;

endmodule

>>> sv/keyed_compacting_order_list.sv
// ----------------------------------------------------------------------------
// keyed_compacting_order_list: packed list of keyed price entries
// Ordered list of up to DEPTH entries held in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per operation; tuser carries the operation code,
//   tdata the key, price and index. Master stream: one result word per
//   operation with the success flag, popped or read entry and new count.
//   Operations: insert at tail, delete front, delete by key, read at index,
//   write at index. A full list, empty list, missing key or index at or
//   beyond the count gives ok 0 and leaves the list unchanged.
//   Each operation walks a token from slot 0 to slot DEPTH-1, one slot per
//   cycle, so the walk through the cell chain sets the rate: the result
//   word is formed when the token leaves the last slot, and the next word
//   is taken only once that result has moved into the output register.
//   The result sits in an output register, so a new word is accepted while
//   the previous result is still stalled; the walk then waits in its final
//   state until the receiver takes the older result.
//   Reset empties the list (count 0); entry contents are left as they were
//   and are never visible since only slots below the count are read.
// ----------------------------------------------------------------------------
module keyed_compacting_order_list #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: key[31:0], price[55:32], index[61:56], zero[63:62]
  input  logic [kol_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: operation[2:0]
  input  logic [kol_pkg::OP_W-1:0]       s_axis_tuser,
  // master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: ok[0], key_out[32:1], price_out[56:33], count[63:57]
  output logic [kol_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import kol_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        pos_q, count_q, count_n;
  op_e                  op_q;
  logic [KEY_W-1:0]     key_q;
  logic [PRICE_W-1:0]   price_q;
  logic [IDX_W-1:0]     idx_q;
  logic [M_TDATA_W-1:0] res_q, res_d;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic                 m_tvalid_q;

  logic [CMPW-1:0]      pos_x, cnt_x, idx_x, cnt_out;
  logic                 full, nonempty, idx_ok, at_idx, at_front, at_tail;
  logic                 accept, walk_done, out_free, ok_c;
  cmd_t                 cmd;

  // chain wiring: index i feeds cell i, index DEPTH leaves the last cell
  logic [DEPTH:0]       tok_w, sh_w;
  entry_t               carry_w [DEPTH+1];
  entry_t               ent_w   [DEPTH];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign walk_done     = tok_w[DEPTH];
  assign out_free      = ~m_tvalid_q | m_axis_tready;

  // --- per-step command, worked out for the slot the token is entering ---
  assign pos_x    = CMPW'(pos_q);
  assign cnt_x    = CMPW'(count_q);
  assign idx_x    = CMPW'(idx_q);
  assign full     = (count_q == CW'(DEPTH));
  assign nonempty = (count_q != '0);
  assign idx_ok   = (idx_x < cnt_x);
  assign at_idx   = (pos_x == idx_x);
  assign at_front = (pos_q == '0);
  assign at_tail  = (pos_x == cnt_x);

  always_comb begin
    cmd            = '0;
    cmd.data.key   = key_q;
    cmd.data.price = price_q;
    cmd.in_range   = (pos_x < cnt_x);
    cmd.del_key    = (op_q == OP_DEL_KEY);
    cmd.force_del  = (op_q == OP_DEL_FRONT) & at_front & nonempty;
    cmd.wr         = ((op_q == OP_INSERT) & at_tail & ~full) |
                     ((op_q == OP_WRITE) & at_idx & idx_ok);
    cmd.cap        = ((op_q == OP_READ) & at_idx & idx_ok) | cmd.force_del;
  end

  // --- cell chain ---
  assign tok_w[0]   = (state_q == ST_WALK) & at_front;
  assign sh_w[0]    = 1'b0;
  assign carry_w[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t next_ent;
    if (i == DEPTH - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_mid
      assign next_ent = ent_w[i+1];
    end

    kol_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok_w[i]),
      .sh_i    (sh_w[i]),
      .carry_i (carry_w[i]),
      .next_i  (next_ent),
      .cmd_i   (cmd),
      .tok_o   (tok_w[i+1]),
      .sh_o    (sh_w[i+1]),
      .carry_o (carry_w[i+1]),
      .ent_o   (ent_w[i])
    );
  end

  // --- result once the token has left the last slot ---
  always_comb begin
    ok_c    = 1'b0;
    count_n = count_q;
    unique case (op_q)
      OP_INSERT: begin
        ok_c = ~full;
        if (ok_c) count_n = count_q + 1'b1;
      end
      OP_DEL_FRONT: begin
        ok_c = nonempty;
        if (ok_c) count_n = count_q - 1'b1;
      end
      OP_DEL_KEY: begin
        ok_c = sh_w[DEPTH];  // a removal shifted the tail down
        if (ok_c) count_n = count_q - 1'b1;
      end
      OP_READ,
      OP_WRITE: begin
        ok_c = idx_ok;
      end
      default: begin
        ok_c = 1'b0;  // unused codes: no change
      end
    endcase
  end

  // capture is zero unless a read or pop took an entry
  assign cnt_out = CMPW'(count_n);
  assign res_d   = {cnt_out[COUNT_W-1:0], carry_w[DEPTH].price,
                    carry_w[DEPTH].key, ok_c};

  // --- control ---
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_WALK;
      ST_WALK: if (walk_done)     state_d = ST_EMIT;
      ST_EMIT: if (out_free)      state_d = ST_IDLE;
      default:                    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pos_q      <= '0;
      count_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pos_q <= '0;
      end else if ((state_q == ST_WALK) && !walk_done) begin
        pos_q <= pos_q + 1'b1;
      end
      if (walk_done) count_q <= count_n;
      if ((state_q == ST_EMIT) && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(s_axis_tuser);
      key_q   <= s_axis_tdata[KEY_W-1:0];
      price_q <= s_axis_tdata[KEY_W +: PRICE_W];
      idx_q   <= s_axis_tdata[KEY_W+PRICE_W +: IDX_W];
    end
    if (walk_done) res_q <= res_d;
    if ((state_q == ST_EMIT) && out_free) m_tdata_q <= res_q;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
  // at most one slot holds the walk token
  a_tok_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_w))
    else $error("walk token in more than one slot");

  // the count never passes the capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CMPW'(DEPTH))
    else $error("entry count above capacity");

  // no walk in flight while a new word can be taken
  a_idle_no_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (tok_w == '0))
    else $error("token in chain while idle");

  // end of the walk always leads to result delivery
  a_done_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done |=> (state_q == ST_EMIT))
    else $error("walk finished without result stage");
`endif

endmodule

>>> dv/keyed_compacting_order_list_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_compacting_order_list_test: self-checking bench for the order list
// Sends operation words through the slave stream, predicts each result word
// from a queue model of the list, and checks the master stream field by field.
// A short directed table comes first, then phases of random fill, drain and
// mixed traffic, with bursts of idling on both streams.
// ----------------------------------------------------------------------------
module keyed_compacting_order_list_test;
  import kol_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned RANDOM_WORDS = 1926;
  localparam int unsigned CALM_WORDS   = 200;   // tail of the run with no idling
  localparam int unsigned POOL_LEN     = 8;
  // longest quiet stretch of a correct run: one walk, a run of sender bursts
  // and a receiver burst, taken ten times over
  localparam int unsigned WATCHDOG_LIMIT = 10 * (DEPTH + 3 + 8 * 12 + 12);

  // codes 5 to 7 are spare; the block answers them with ok 0
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  // insert share in percent for the fill, drain and mixed phases
  localparam int unsigned PHASE_MIX [3] = '{70, 12, 35};

  // master tdata layout, lowest bit first: ok, key_out, price_out, count
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [PRICE_W-1:0] price;
    logic [KEY_W-1:0]   key;
    logic               ok;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [IDX_W-1:0]   idx;
    logic               typed;  // want holds the answer; otherwise predicted
    list_result_t       want;
  } plan_row_t;

  function automatic list_result_t outcome(logic ok, logic [KEY_W-1:0] key,
                                           logic [PRICE_W-1:0] price,
                                           logic [COUNT_W-1:0] count);
    list_result_t r;
    r.ok = ok;
    r.key = key;
    r.price = price;
    r.count = count;
    return r;
  endfunction

  localparam list_result_t UNTYPED = '0;
  localparam int unsigned PLAN_LEN = 24;

  // Directed table: empty-list failures, spare codes, extreme keys and
  // prices, index at and beyond the count, duplicate keys, missing key.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{OP_DEL_FRONT, 32'h0, 24'h0, 6'd0, 1'b1, outcome(1'b0, 32'h0, 24'h0, 7'd0)},
    '{OP_DEL_KEY, 32'h0, 24'h0, 6'd0, 1'b1, outcome(1'b0, 32'h0, 24'h0, 7'd0)},
    '{OP_READ, 32'h0, 24'h0, 6'd0, 1'b1, outcome(1'b0, 32'h0, 24'h0, 7'd0)},
    '{OP_WRITE, 32'hFFFF_FFFF, 24'hFF_FFFF, 6'd0, 1'b1,
      outcome(1'b0, 32'h0, 24'h0, 7'd0)},
    '{OP_SPARE_LO, 32'h0, 24'h0, 6'd0, 1'b1, outcome(1'b0, 32'h0, 24'h0, 7'd0)},
    '{OP_SPARE_HI, 32'hFFFF_FFFF, 24'hFF_FFFF, 6'd63, 1'b1,
      outcome(1'b0, 32'h0, 24'h0, 7'd0)},
    '{OP_INSERT, 32'hFFFF_FFFF, 24'hFF_FFFF, 6'd63, 1'b1,
      outcome(1'b1, 32'h0, 24'h0, 7'd1)},
    '{OP_INSERT, 32'h0, 24'h0, 6'd0, 1'b1, outcome(1'b1, 32'h0, 24'h0, 7'd2)},
    '{OP_READ, 32'h0, 24'h0, 6'd0, 1'b1,
      outcome(1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 7'd2)},
    '{OP_READ, 32'hFFFF_FFFF, 24'hFF_FFFF, 6'd1, 1'b1,
      outcome(1'b1, 32'h0, 24'h0, 7'd2)},
    '{OP_READ, 32'h0, 24'h0, 6'd63, 1'b1, outcome(1'b0, 32'h0, 24'h0, 7'd2)},
    '{OP_READ, 32'h0, 24'h0, 6'd2, 1'b1, outcome(1'b0, 32'h0, 24'h0, 7'd2)},
    '{OP_WRITE, 32'h5555_AAAA, 24'hA5_A5A5, 6'd1, 1'b1,
      outcome(1'b1, 32'h0, 24'h0, 7'd2)},
    '{OP_WRITE, 32'h1234_5678, 24'h12_3456, 6'd2, 1'b1,
      outcome(1'b0, 32'h0, 24'h0, 7'd2)},
    '{OP_INSERT, 32'h1234_5678, 24'h5A_5A5A, 6'd0, 1'b0, UNTYPED},
    '{OP_INSERT, 32'h5555_AAAA, 24'h3C_3C3C, 6'd0, 1'b0, UNTYPED},
    '{OP_DEL_KEY, 32'h5555_AAAA, 24'h0, 6'd0, 1'b0, UNTYPED},
    '{OP_READ, 32'h0, 24'h0, 6'd1, 1'b0, UNTYPED},
    '{OP_DEL_KEY, 32'hDEAD_BEEF, 24'h0, 6'd0, 1'b0, UNTYPED},
    '{OP_SPARE_MID, 32'hAAAA_AAAA, 24'h55_5555, 6'd42, 1'b0, UNTYPED},
    '{OP_DEL_FRONT, 32'h0, 24'h0, 6'd0, 1'b0, UNTYPED},
    '{OP_DEL_FRONT, 32'h0, 24'h0, 6'd0, 1'b0, UNTYPED},
    '{OP_DEL_FRONT, 32'h0, 24'h0, 6'd0, 1'b0, UNTYPED},
    '{OP_DEL_FRONT, 32'h0, 24'h0, 6'd0, 1'b1, outcome(1'b0, 32'h0, 24'h0, 7'd0)}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // key, price, index, zero pad
  logic [OP_W-1:0]       s_axis_tuser = '0;   // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;        // ok, key_out, price_out, count

  entry_t        held_entries [$];   // predicted list contents, slot 0 first
  list_result_t  due_results [$];    // results still to come, oldest first
  logic [KEY_W-1:0] key_pool [POOL_LEN];
  bit            calm = 1'b0;        // set for the tail: no idling on either side
  int unsigned   mismatches = 0;
  int unsigned   words_checked = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   stall_left = 0;

  keyed_compacting_order_list #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Queue model of the list: applies one operation and gives its result.
  function automatic list_result_t apply_order_op(logic [OP_W-1:0] op,
                                                  logic [KEY_W-1:0] key,
                                                  logic [PRICE_W-1:0] price,
                                                  logic [IDX_W-1:0] idx);
    list_result_t r;
    int hit;
    r = '0;
    hit = -1;
    case (op)
      OP_INSERT: begin
        if (held_entries.size() < DEPTH) begin
          held_entries.push_back('{key: key, price: price});
          r.ok = 1'b1;
        end
      end
      OP_DEL_FRONT: begin
        if (held_entries.size() != 0) begin
          r.key = held_entries[0].key;
          r.price = held_entries[0].price;
          void'(held_entries.pop_front());
          r.ok = 1'b1;
        end
      end
      OP_DEL_KEY: begin
        // first match only; later duplicates stay
        for (int i = 0; i < held_entries.size(); i++) begin
          if (hit < 0 && held_entries[i].key == key) hit = i;
        end
        if (hit >= 0) begin
          held_entries.delete(hit);
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (idx < held_entries.size()) begin
          r.key = held_entries[idx].key;
          r.price = held_entries[idx].price;
          r.ok = 1'b1;
        end
      end
      OP_WRITE: begin
        if (idx < held_entries.size()) begin
          held_entries[idx] = '{key: key, price: price};
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(held_entries.size());
    return r;
  endfunction

  // Presents one word and holds it until taken; the prediction is made at
  // the edge that accepts it, so it sees the list in acceptance order.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [PRICE_W-1:0] price,
                           input logic [IDX_W-1:0] idx,
                           input logic typed, input list_result_t want);
    list_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {{(S_TDATA_W - IDX_W - PRICE_W - KEY_W){1'b0}}, idx, price, key};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_order_op(op, key, price, idx);
    due_results.push_back(typed ? want : predicted);
  endtask

  // Sender gap after a word: mostly none, sometimes a burst, now and then a
  // run of bursts long enough to land anywhere in the walk.
  task automatic sender_gap();
    int unsigned bursts;
    bursts = 0;
    if (!calm) begin
      if ($urandom_range(0, 19) == 0) bursts = $urandom_range(1, 8);
      else if ($urandom_range(0, 4) == 0) bursts = 1;
    end
    if (bursts != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (bursts) repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Random word: spare codes now and then, insert share set by the phase,
  // keys mostly from a small pool so duplicates and hits are common.
  task automatic pick_word(input int unsigned insert_pct,
                           output logic [OP_W-1:0] op, output logic [KEY_W-1:0] key,
                           output logic [PRICE_W-1:0] price,
                           output logic [IDX_W-1:0] idx);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    price = PRICE_W'($urandom);
    idx = IDX_W'($urandom);
    key = ($urandom_range(0, 9) < 3) ? KEY_W'($urandom)
                                      : key_pool[$urandom_range(0, POOL_LEN - 1)];
    if (roll < 2) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else if (roll < 2 + insert_pct) op = OP_INSERT;
    else op = OP_W'($urandom_range(OP_DEL_FRONT, OP_WRITE));
    if (held_entries.size() != 0 && $urandom_range(0, 9) < 7) begin
      if (op == OP_DEL_KEY)
        key = held_entries[$urandom_range(0, held_entries.size() - 1)].key;
      else if (op == OP_READ || op == OP_WRITE)
        idx = IDX_W'($urandom_range(0, held_entries.size() - 1));
    end
  endtask

  // Receiver: random stall bursts with ready held low, none in the tail.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: result word %0d, %s: got %h, want %h", $time, words_checked,
             what, got, want);
    mismatches++;
  endtask

  // Result checker: every accepted result word against the oldest one due.
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (due_results.size() == 0) begin
        report_mismatch("word with none due", 64'(got), 64'h0);
      end else begin
        want = due_results.pop_front();
        if (got.ok !== want.ok) report_mismatch("ok", 64'(got.ok), 64'(want.ok));
        if (got.key !== want.key) report_mismatch("key_out", 64'(got.key), 64'(want.key));
        if (got.price !== want.price)
          report_mismatch("price_out", 64'(got.price), 64'(want.price));
        if (got.count !== want.count)
          report_mismatch("count", 64'(got.count), 64'(want.count));
      end
      words_checked++;
    end
  end

  // Watchdog: a long stretch with no word moving on either stream is a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [IDX_W-1:0]   idx;
    int unsigned        sent;
    int unsigned        phase_left;
    int unsigned        insert_pct;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_LEN; i++) key_pool[i] = KEY_W'($urandom);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      send_word(PLAN[i].op, PLAN[i].key, PLAN[i].price, PLAN[i].idx, PLAN[i].typed,
                PLAN[i].want);
      sender_gap();
    end

    // random phases; each ends with the sender holding off until every
    // result due has come back, so phase boundaries see an idle block
    sent = 0;
    phase_left = 0;
    insert_pct = PHASE_MIX[2];
    while (sent < RANDOM_WORDS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(60, 220);
        insert_pct = PHASE_MIX[$urandom_range(0, 2)];
      end
      if (sent >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      pick_word(insert_pct, op, key, price, idx);
      send_word(op, key, price, idx, 1'b0, UNTYPED);
      sent++;
      phase_left--;
      if (phase_left == 0 && sent < RANDOM_WORDS) begin
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk_i);
      end else begin
        sender_gap();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
